@@ rtl/mqf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mqf_pkg
// shared types and constants of the multi-queue message fifo: field widths,
// status codes and the command word passed from the front to the back
// ----------------------------------------------------------------------------
package mqf_pkg;

   localparam int WORD_W         = 64;
   localparam int BYTES_PER_WORD = 8;
   localparam int QID_W          = 3;
   localparam int STATUS_W       = 2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADQ  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = 2;
   localparam int CMD_CNT_W = 3;

   typedef struct packed {
      logic                wr_en;
      logic                emit_status;
      logic                read_msg;
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   data;
   } mqf_cmd_type;

endpackage
`default_nettype wire

@@ rtl/mqf_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mqf_ram
// generic simple dual-port ram, one write port and one read port with
// registered read data
// ----------------------------------------------------------------------------
module mqf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/mqf_cmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mqf_cmd_queue
// short register fifo of commands between the front and the back
// ----------------------------------------------------------------------------
module mqf_cmd_queue #(
   parameter int WIDTH = 80
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  valid,
   output logic                  full
);
   import mqf_pkg::*;

   logic [WIDTH-1:0]     entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign valid    = (count_ff != '0);
   assign full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/mqf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mqf_front
// accepts request words, keeps head, tail and fill count of every queue and
// the state of the send in progress, and makes a command of each word with an effect
// ----------------------------------------------------------------------------
module mqf_front #(
   parameter int QUEUES = 4,
   parameter int SLOTS  = 8,
   parameter int WORDS  = 8,
   parameter int ADDR_W = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         req_mode,
   input  wire logic [mqf_pkg::QID_W-1:0]    req_queue_id,
   input  wire logic [mqf_pkg::WORD_W-1:0]   req_data_word,
   output logic                              push,
   output mqf_pkg::mqf_cmd_type              cmd,
   output logic      [ADDR_W-1:0]            cmd_addr
);
   import mqf_pkg::*;

   localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [SW-1:0]       head_ff  [QUEUES];
   logic [SW-1:0]       tail_ff  [QUEUES];
   logic [CW-1:0]       count_ff [QUEUES];
   logic [WW-1:0]       pos_ff;
   logic [QID_W-1:0]    target_ff;
   logic [STATUS_W-1:0] code_ff;

   logic                first;
   logic                send_last;
   logic [QID_W-1:0]    eff_target;
   logic [QID_W-1:0]    sel_q;
   logic                q_ok;
   logic [QW-1:0]       qi;
   logic [CW-1:0]       cnt;
   logic [SW-1:0]       head_sel;
   logic [SW-1:0]       tail_sel;
   logic [STATUS_W-1:0] new_code;
   logic [STATUS_W-1:0] eff_code;

   function automatic logic [ADDR_W-1:0] slot_base(input logic [QW-1:0] q,
                                                   input logic [SW-1:0] slot);
      slot_base = ADDR_W'((int'(q) * SLOTS + int'(slot)) * WORDS);
   endfunction

   function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] slot);
      slot_next = (slot == SW'(SLOTS - 1)) ? '0 : slot + 1'b1;
   endfunction

   assign first      = (pos_ff == '0);
   assign send_last  = (pos_ff == WW'(WORDS - 1));
   assign eff_target = first ? req_queue_id : target_ff;
   assign sel_q      = req_mode ? req_queue_id : eff_target;
   assign q_ok       = ({1'b0, sel_q} < (QID_W + 1)'(QUEUES));
   assign qi         = sel_q[QW-1:0];
   assign cnt        = q_ok ? count_ff[qi] : '0;
   assign head_sel   = q_ok ? head_ff[qi] : '0;
   assign tail_sel   = q_ok ? tail_ff[qi] : '0;

   always_comb begin
      if (!q_ok) begin
         new_code = ST_BADQ;
      end else if (cnt >= CW'(SLOTS)) begin
         new_code = ST_FULL;
      end else begin
         new_code = ST_OK;
      end
      eff_code = first ? new_code : code_ff;
   end

   always_comb begin
      cmd             = '0;
      cmd.data        = req_data_word;
      cmd_addr        = '0;
      if (!req_mode) begin
         cmd.wr_en       = (eff_code == ST_OK);
         cmd.emit_status = send_last;
         cmd.status      = eff_code;
         cmd_addr        = slot_base(qi, tail_sel) + ADDR_W'(pos_ff);
      end else if (!q_ok) begin
         cmd.emit_status = 1'b1;
         cmd.status      = ST_BADQ;
      end else if (cnt == '0) begin
         cmd.emit_status = 1'b1;
         cmd.status      = ST_EMPTY;
      end else begin
         cmd.read_msg    = 1'b1;
         cmd_addr        = slot_base(qi, head_sel);
      end
      push = accept & (cmd.wr_en | cmd.emit_status | cmd.read_msg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         pos_ff    <= '0;
         target_ff <= '0;
         code_ff   <= ST_OK;
      end else if (accept) begin
         if (!req_mode) begin
            if (first) begin
               target_ff <= req_queue_id;
               code_ff   <= new_code;
            end
            pos_ff <= send_last ? '0 : pos_ff + 1'b1;
            if (send_last && eff_code == ST_OK) begin
               tail_ff[qi]  <= slot_next(tail_sel);
               count_ff[qi] <= cnt + 1'b1;
            end
         end else if (q_ok && cnt != '0) begin
            head_ff[qi]  <= slot_next(head_sel);
            count_ff[qi] <= cnt - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/mqf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mqf_back
// carries out commands: writes message words, streams a stored message out
// of the ram one word per cycle, and issues status words
// ----------------------------------------------------------------------------
module mqf_back #(
   parameter int WORDS  = 8,
   parameter int ADDR_W = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire mqf_pkg::mqf_cmd_type          q_cmd,
   input  wire logic [ADDR_W-1:0]             q_addr,
   output logic                               pop,
   output logic                               ram_wr_en,
   output logic      [ADDR_W-1:0]             ram_wr_addr,
   output logic      [mqf_pkg::WORD_W-1:0]    ram_wr_data,
   output logic                               ram_rd_en,
   output logic      [ADDR_W-1:0]             ram_rd_addr,
   input  wire logic [mqf_pkg::WORD_W-1:0]    ram_rd_data,
   output logic                               rsp_strobe,
   output logic      [mqf_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [mqf_pkg::WORD_W-1:0]    rsp_read_word,
   output logic                               rsp_last
);
   import mqf_pkg::*;

   localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic                rd_active_ff;
   logic [WW-1:0]       rd_pos_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic                out_rd_ff;
   logic                out_last_ff;
   logic                stat_valid_ff;
   logic [STATUS_W-1:0] stat_code_ff;
   logic                take;
   logic                issue_new;
   logic                issue_last;

   assign take        = q_valid & ~rd_active_ff;
   assign pop         = take;
   assign ram_wr_en   = take & q_cmd.wr_en;
   assign ram_wr_addr = q_addr;
   assign ram_wr_data = q_cmd.data;
   assign issue_new   = take & q_cmd.read_msg;
   assign ram_rd_en   = issue_new | rd_active_ff;
   assign ram_rd_addr = rd_active_ff ? rd_addr_ff : q_addr;
   assign issue_last  = rd_active_ff ? (rd_pos_ff == WW'(WORDS - 1)) : 1'(WORDS == 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_active_ff  <= 1'b0;
         out_rd_ff     <= 1'b0;
         stat_valid_ff <= 1'b0;
      end else begin
         if (issue_new) begin
            rd_active_ff <= 1'(WORDS > 1);
         end else if (rd_active_ff && issue_last) begin
            rd_active_ff <= 1'b0;
         end
         out_rd_ff     <= ram_rd_en;
         stat_valid_ff <= take & q_cmd.emit_status;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_new) begin
         rd_pos_ff  <= WW'(1);
         rd_addr_ff <= q_addr + 1'b1;
      end else if (rd_active_ff) begin
         rd_pos_ff  <= rd_pos_ff + 1'b1;
         rd_addr_ff <= rd_addr_ff + 1'b1;
      end
      out_last_ff  <= issue_last;
      stat_code_ff <= q_cmd.status;
   end

   assign rsp_strobe    = out_rd_ff | stat_valid_ff;
   assign rsp_status    = out_rd_ff ? ST_OK : stat_code_ff;
   assign rsp_read_word = out_rd_ff ? ram_rd_data : '0;
   assign rsp_last      = out_rd_ff ? out_last_ff : 1'b1;

endmodule
`default_nettype wire

@@ rtl/multi_queue_message_fifo_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_message_fifo_unit
// several circular message queues sharing one message ram
// ----------------------------------------------------------------------------
// A send is MSG_BYTES/8 request words with mode 0, one per cycle while busy is
// low; the queue comes from the first word and one status word follows the
// last. A receive is one request word with mode 1 and yields MSG_BYTES/8 read
// words, one per cycle, or a single error status. Results pass through the
// command queue and the registered back-end outputs, appear later when earlier
// commands are still waiting, and cannot be held off. Send words are taken one
// per cycle while busy is low; a receive holds the back end while the ram read
// port streams the message, and busy rises once the four-entry command queue
// between front and back is full. The ram needs no clearing pass after reset.
module multi_queue_message_fifo_unit #(
   parameter int QUEUES    = 4,
   parameter int SLOTS     = 8,
   parameter int MSG_BYTES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_mode,
   input  wire logic [mqf_pkg::QID_W-1:0]     req_queue_id,
   input  wire logic [mqf_pkg::WORD_W-1:0]    req_data_word,
   output logic                               rsp_strobe,
   output logic      [mqf_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [mqf_pkg::WORD_W-1:0]    rsp_read_word,
   output logic                               rsp_last
);
   import mqf_pkg::*;

   localparam int WORDS    = MSG_BYTES / BYTES_PER_WORD;
   localparam int DEPTH    = QUEUES * SLOTS * WORDS;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMD_BITS = $bits(mqf_cmd_type);
   localparam int ENTRY_W  = CMD_BITS + ADDR_W;

   logic                 accept;
   logic                 push;
   mqf_cmd_type          f_cmd;
   logic [ADDR_W-1:0]    f_addr;
   logic [ENTRY_W-1:0]   q_data;
   logic                 q_valid;
   logic                 q_full;
   logic                 pop;
   mqf_cmd_type          b_cmd;
   logic [ADDR_W-1:0]    b_addr;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [WORD_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [WORD_W-1:0]    ram_rd_data;

   assign busy   = q_full;
   assign accept = start & ~busy;
   assign b_addr = q_data[ENTRY_W-1 -: ADDR_W];
   assign b_cmd  = mqf_cmd_type'(q_data[CMD_BITS-1:0]);

   mqf_front #(
      .QUEUES (QUEUES),
      .SLOTS  (SLOTS),
      .WORDS  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_mode      (req_mode),
      .req_queue_id  (req_queue_id),
      .req_data_word (req_data_word),
      .push          (push),
      .cmd           (f_cmd),
      .cmd_addr      (f_addr)
   );

   mqf_cmd_queue #(
      .WIDTH (ENTRY_W)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_addr, f_cmd}),
      .pop       (pop),
      .pop_data  (q_data),
      .valid     (q_valid),
      .full      (q_full)
   );

   mqf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mqf_back #(
      .WORDS  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (b_cmd),
      .q_addr        (b_addr),
      .pop           (pop),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_read_word (rsp_read_word),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire
